/* rtl/srsc_pkg.sv */
// Shared types, constants and codes for the sensor record sequence checker.
`default_nettype none

package srsc_pkg;

  localparam int RECORD_BYTES = 36;
  localparam int WORD_BITS = 32;
  localparam int FT_WORDS = 6;
  localparam int FORCE_WORDS = 3;
  localparam int FIELD_BITS = 48;
  localparam int POS_BITS = 6;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // word positions inside a record
  localparam int SEQ_WORD = 0;
  localparam int STATUS_WORD = 2;
  localparam int FT_FIRST = 3;

  localparam int MID_DEPTH_DEFAULT = 2;
  localparam int OUT_DEPTH_DEFAULT = 8;

  localparam int SCALE_SHIFT = 16;
  localparam logic [63:0] ROUND_BIAS = 64'h8000;

  localparam logic CFG_FORCE_GAIN = 1'b0;
  localparam logic CFG_TORQUE_GAIN = 1'b1;
  localparam logic [WORD_BITS-1:0] GAIN_RESET = 32'd4295;

  typedef enum logic [1:0] {
    OUTCOME_ACCEPTED   = 2'd0,
    OUTCOME_STALE      = 2'd1,
    OUTCOME_SIZE_ERROR = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } item_t;

  typedef struct packed {
    outcome_t               outcome;
    logic [31:0]            sample_number;
    logic signed [47:0]     force_x;
    logic signed [47:0]     force_y;
    logic signed [47:0]     force_z;
    logic signed [47:0]     torque_x;
    logic signed [47:0]     torque_y;
    logic signed [47:0]     torque_z;
    logic [31:0]            device_status;
    logic [31:0]            lost_total;
    logic [31:0]            out_of_order_total;
  } result_t;

  typedef struct packed {
    logic                              size_error;
    logic [WORD_BITS-1:0]              seq_word;
    logic [WORD_BITS-1:0]              status_word;
    logic [FT_WORDS-1:0][WORD_BITS-1:0] ft_words;
  } record_t;

endpackage

`default_nettype wire

/* rtl/sensor_record_sequence_checker_top.sv */
// Top level of the sensor record sequence checker.
//
// Input channel: one datagram byte per word (item), push/full. A word is
// taken at a clock edge with push high and full low; one byte per cycle is
// sustained while full is low. end_of_datagram marks the last byte of a datagram.
// Result channel: empty/pop. One result word per datagram, oldest first,
// shown on result while empty is low, taken with pop high.
// The result of a datagram passes, after its last byte is taken, through the
// mid queue, check stage, multiply stage and result queue. The back end
// takes one datagram per cycle while the result queue has room for it, so
// datagrams of any length, down to one byte, flow at one word per cycle.
// Config: cfg_we writes force_gain (index 0) or torque_gain (index 1);
// write only while no datagram is in flight.
// Reset (rst, synchronous) clears the byte count, counters, status latch,
// previous sequence and both queues; gains return to 4295.
// When the receiver stalls, the result queue (OUT_DEPTH words) fills, the
// back end stops taking records, the mid queue fills and full rises.
`default_nettype none

module sensor_record_sequence_checker_top import srsc_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  item_t                item,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  logic    accept;
  logic    rec_push;
  record_t rec_in;
  logic    mid_empty;
  logic    mid_pop;
  logic [$bits(record_t)-1:0] mid_bits;

  assign accept = push && !full;

  srsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  srsc_fifo #(
    .WIDTH ($bits(record_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_data (rec_in),
    .full      (full),
    .pop       (mid_pop),
    .pop_data  (mid_bits),
    .empty     (mid_empty),
    .level     ()
  );

  srsc_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_valid (!mid_empty),
    .rec       (record_t'(mid_bits)),
    .rec_pop   (mid_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

/* rtl/srsc_fifo.sv */
// Small register FIFO used between the front and back and for results.
`default_nettype none

module srsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int LVL_BITS = $clog2(DEPTH+1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [LVL_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign full = count == LVL_BITS'(DEPTH);
  assign empty = count == '0;
  assign level = count;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + LVL_BITS'(1);
        2'b01: count <= count - LVL_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/srsc_front.sv */
// Byte assembler: counts datagram bytes, keeps a record shift line, classifies size.
`default_nettype none

module srsc_front import srsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  output logic    rec_push,
  output record_t rec
);

  localparam int LINE_BITS = (RECORD_BYTES - 1) * 8;
  localparam int REC_BITS = RECORD_BYTES * 8;

  logic [POS_BITS-1:0]  pos;
  logic [POS_BITS-1:0]  pos_inc;
  logic [LINE_BITS-1:0] byte_line;
  logic [REC_BITS-1:0]  rec_bits;

  assign pos_inc = (pos == POS_MAX) ? pos : pos + POS_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= item.end_of_datagram ? '0 : pos_inc;
    end
  end

  // oldest byte sits at the top of the line
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_line <= {byte_line[LINE_BITS-9:0], item.data_byte};
    end
  end

  assign rec_bits = {byte_line, item.data_byte};

  always_comb begin
    rec.size_error = pos_inc != POS_BITS'(RECORD_BYTES);
    rec.seq_word = rec_bits[REC_BITS-1-SEQ_WORD*WORD_BITS -: WORD_BITS];
    rec.status_word = rec_bits[REC_BITS-1-STATUS_WORD*WORD_BITS -: WORD_BITS];
    for (int j = 0; j < FT_WORDS; j++) begin
      rec.ft_words[j] = rec_bits[REC_BITS-1-(FT_FIRST+j)*WORD_BITS -: WORD_BITS];
    end
  end

  assign rec_push = accept && item.end_of_datagram;

endmodule

`default_nettype wire

/* rtl/srsc_back.sv */
// Sequence check, counters, gain scaling pipeline and result queue.
`default_nettype none

module srsc_back import srsc_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data,
  input  logic                 rec_valid,
  input  record_t              rec,
  output logic                 rec_pop,
  output result_t              result,
  output logic                 empty,
  input  logic                 pop
);

  localparam int LVL_BITS = $clog2(OUT_DEPTH+1);
  localparam int CRD_BITS = LVL_BITS + 1;

  logic [WORD_BITS-1:0] force_gain;
  logic [WORD_BITS-1:0] torque_gain;
  logic [WORD_BITS-1:0] prev_seq;
  logic [WORD_BITS-1:0] sample_cnt;
  logic [WORD_BITS-1:0] lost_cnt;
  logic [WORD_BITS-1:0] stale_cnt;
  logic [WORD_BITS-1:0] status_latch;

  logic [WORD_BITS-1:0] diff;
  logic                 stale_now;
  logic                 take;
  logic                 issue;
  logic [CRD_BITS-1:0]  committed;
  logic [LVL_BITS-1:0]  out_level;
  logic                 out_full;

  logic [WORD_BITS-1:0] sample_cnt_next;
  logic [WORD_BITS-1:0] lost_cnt_next;
  logic [WORD_BITS-1:0] stale_cnt_next;
  logic [WORD_BITS-1:0] status_latch_next;
  result_t              meta_next;
  logic [FT_WORDS-1:0][WORD_BITS-1:0] data_next;

  logic                 s1_valid;
  result_t              s1_meta;
  logic [FT_WORDS-1:0][WORD_BITS-1:0] s1_data;
  logic                 s2_valid;
  result_t              s2_meta;
  logic [FT_WORDS-1:0][63:0] s2_prod;

  logic signed [64:0]   prod_full [FT_WORDS];
  logic [63:0]          rnd [FT_WORDS];
  result_t              out_word;
  logic [$bits(result_t)-1:0] out_bits;

  // stage 1: sequence check and counter update
  assign committed = CRD_BITS'(out_level) + CRD_BITS'(s1_valid) + CRD_BITS'(s2_valid);
  assign issue = rec_valid && (committed < CRD_BITS'(OUT_DEPTH));
  assign rec_pop = issue;

  assign diff = rec.seq_word - prev_seq;
  assign stale_now = (diff == '0) || diff[WORD_BITS-1];
  assign take = !rec.size_error && !stale_now;

  always_comb begin
    sample_cnt_next = sample_cnt;
    lost_cnt_next = lost_cnt;
    stale_cnt_next = stale_cnt;
    status_latch_next = status_latch;
    if (!rec.size_error) begin
      status_latch_next = rec.status_word;
      if (stale_now) begin
        stale_cnt_next = stale_cnt + 32'd1;
      end else begin
        sample_cnt_next = sample_cnt + 32'd1;
        lost_cnt_next = lost_cnt + (diff - 32'd1);
      end
    end

    meta_next = '0;
    if (rec.size_error) begin
      meta_next.outcome = OUTCOME_SIZE_ERROR;
    end else if (stale_now) begin
      meta_next.outcome = OUTCOME_STALE;
    end else begin
      meta_next.outcome = OUTCOME_ACCEPTED;
    end
    meta_next.sample_number = take ? sample_cnt : '0;
    meta_next.device_status = status_latch_next;
    meta_next.lost_total = lost_cnt_next;
    meta_next.out_of_order_total = stale_cnt_next;

    for (int j = 0; j < FT_WORDS; j++) begin
      data_next[j] = take ? rec.ft_words[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_gain <= GAIN_RESET;
      torque_gain <= GAIN_RESET;
      prev_seq <= '0;
      sample_cnt <= '0;
      lost_cnt <= '0;
      stale_cnt <= '0;
      status_latch <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FORCE_GAIN: force_gain <= cfg_data;
          CFG_TORQUE_GAIN: torque_gain <= cfg_data;
          default: ;
        endcase
      end
      if (issue) begin
        if (!rec.size_error) begin
          prev_seq <= rec.seq_word;
        end
        sample_cnt <= sample_cnt_next;
        lost_cnt <= lost_cnt_next;
        stale_cnt <= stale_cnt_next;
        status_latch <= status_latch_next;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // stage 2: signed word times unsigned Q0.32 gain
  always_comb begin
    for (int j = 0; j < FT_WORDS; j++) begin
      prod_full[j] = $signed(s1_data[j]) *
                     $signed({1'b0, (j < FORCE_WORDS) ? force_gain : torque_gain});
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta <= meta_next;
      s1_data <= data_next;
    end
    if (s1_valid) begin
      s2_meta <= s1_meta;
      for (int j = 0; j < FT_WORDS; j++) begin
        s2_prod[j] <= prod_full[j][63:0];
      end
    end
  end

  // stage 3: round to nearest, Q32.32 to Q32.16
  always_comb begin
    for (int j = 0; j < FT_WORDS; j++) begin
      rnd[j] = s2_prod[j] + ROUND_BIAS;
    end
    out_word = s2_meta;
    out_word.force_x = rnd[0][SCALE_SHIFT +: FIELD_BITS];
    out_word.force_y = rnd[1][SCALE_SHIFT +: FIELD_BITS];
    out_word.force_z = rnd[2][SCALE_SHIFT +: FIELD_BITS];
    out_word.torque_x = rnd[3][SCALE_SHIFT +: FIELD_BITS];
    out_word.torque_y = rnd[4][SCALE_SHIFT +: FIELD_BITS];
    out_word.torque_z = rnd[5][SCALE_SHIFT +: FIELD_BITS];
  end

  srsc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (out_word),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_bits),
    .empty     (empty),
    .level     (out_level)
  );

  assign result = result_t'(out_bits);

`ifndef SYNTH
  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !out_full)
    else $error("result queue overflow");

  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    issue && take |=> s1_valid && s1_meta.outcome == OUTCOME_ACCEPTED &&
                      sample_cnt == $past(sample_cnt) + 32'd1)
    else $error("accepted sample not counted");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_meta.outcome != OUTCOME_ACCEPTED |->
      s1_meta.sample_number == '0 && s1_data == '0)
    else $error("rejected word carries data");

  a_size_error_keeps: assert property (@(posedge clk) disable iff (rst)
    issue && rec.size_error |=> prev_seq == $past(prev_seq) &&
                                status_latch == $past(status_latch) &&
                                stale_cnt == $past(stale_cnt))
    else $error("size error changed state");
`endif

endmodule

`default_nettype wire

/* sim/sensor_record_sequence_checker_top_test.sv */
// Testbench for the sensor record sequence checker: byte stream in, checked result words out.
`timescale 1ns / 1ps

module sensor_record_sequence_checker_top_test;
  import srsc_pkg::*;

  typedef logic [7:0] octet_q_t[$];
  typedef logic [FT_WORDS-1:0][WORD_BITS-1:0] ft_set_t;

  class sample_scoreboard;
    logic [WORD_BITS-1:0] force_gain, torque_gain;
    logic [POS_BITS-1:0]  byte_pos;
    logic [7:0]           rec [RECORD_BYTES];
    logic [WORD_BITS-1:0] last_seq, samples, lost, stale, status;
    result_t              pending_samples[$];
    int                   fails;

    function new();
      force_gain = GAIN_RESET;
      torque_gain = GAIN_RESET;
      byte_pos = '0;
      foreach (rec[i]) rec[i] = '0;
      last_seq = '0;
      samples = '0;
      lost = '0;
      stale = '0;
      status = '0;
      fails = 0;
    endfunction

    function void set_gains(logic [WORD_BITS-1:0] fg, logic [WORD_BITS-1:0] tg);
      force_gain = fg;
      torque_gain = tg;
    endfunction

    function logic [WORD_BITS-1:0] word_of(int idx);
      return {rec[4*idx], rec[4*idx+1], rec[4*idx+2], rec[4*idx+3]};
    endfunction

    // signed Q32.0 times unsigned Q0.32, rounded to Q32.16
    function logic signed [FIELD_BITS-1:0] q16_scale(logic [WORD_BITS-1:0] w,
                                                     logic [WORD_BITS-1:0] g);
      longint prod;
      prod = longint'($signed(w)) * longint'({32'd0, g});
      prod = prod + longint'(ROUND_BIAS);
      prod = prod >>> SCALE_SHIFT;
      return prod[FIELD_BITS-1:0];
    endfunction

    function void take_byte(item_t it);
      result_t              r;
      logic [WORD_BITS-1:0] seq, diff;
      int                   count;
      if (byte_pos < RECORD_BYTES) rec[byte_pos] = it.data_byte;
      if (byte_pos != POS_MAX) byte_pos++;
      if (!it.end_of_datagram) return;
      count = byte_pos;
      byte_pos = '0;
      r = '0;
      if (count != RECORD_BYTES) begin
        r.outcome = OUTCOME_SIZE_ERROR;
      end else begin
        seq = word_of(SEQ_WORD);
        diff = seq - last_seq;
        status = word_of(STATUS_WORD);
        last_seq = seq;
        if (diff == 0 || diff[WORD_BITS-1]) begin
          stale++;
          r.outcome = OUTCOME_STALE;
        end else begin
          r.outcome = OUTCOME_ACCEPTED;
          r.sample_number = samples;
          samples++;
          r.force_x = q16_scale(word_of(FT_FIRST), force_gain);
          r.force_y = q16_scale(word_of(FT_FIRST + 1), force_gain);
          r.force_z = q16_scale(word_of(FT_FIRST + 2), force_gain);
          r.torque_x = q16_scale(word_of(FT_FIRST + 3), torque_gain);
          r.torque_y = q16_scale(word_of(FT_FIRST + 4), torque_gain);
          r.torque_z = q16_scale(word_of(FT_FIRST + 5), torque_gain);
          lost = lost + (diff - 1);
        end
      end
      r.device_status = status;
      r.lost_total = lost;
      r.out_of_order_total = stale;
      pending_samples.push_back(r);
    endfunction

    task report(string msg);
      if (fails < 50) $display("ERROR @%0t: %s", $time, msg);
      fails++;
    endtask

    task compare(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_sample(result_t got);
      result_t want;
      if (pending_samples.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pending_samples.pop_front();
      compare("outcome", got.outcome, want.outcome);
      compare("sample_number", got.sample_number, want.sample_number);
      compare("force_x", got.force_x, want.force_x);
      compare("force_y", got.force_y, want.force_y);
      compare("force_z", got.force_z, want.force_z);
      compare("torque_x", got.torque_x, want.torque_x);
      compare("torque_y", got.torque_y, want.torque_y);
      compare("torque_z", got.torque_z, want.torque_z);
      compare("device_status", got.device_status, want.device_status);
      compare("lost_total", got.lost_total, want.lost_total);
      compare("out_of_order_total", got.out_of_order_total, want.out_of_order_total);
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  item_t                item = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_FORCE_GAIN;
  logic [WORD_BITS-1:0] cfg_data = '0;

  sample_scoreboard     sb = new();
  bit                   sender_idles = 1'b1;
  bit                   receiver_idles = 1'b1;
  int                   stall_cycles = 0;
  logic [WORD_BITS-1:0] seq_sent = '0;

  sensor_record_sequence_checker_top uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sensor_record_sequence_checker_top_test: FAIL");
    $finish;
  end

  // result side: random pops, plus a counted hold-off on request
  initial begin
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        stall_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= !(receiver_idles && $urandom_range(99) < 9);
      end
      @(posedge clk);
      if (pop && empty === 1'b0) sb.check_sample(result);
    end
  end

  task automatic send_item(input item_t it);
    @(negedge clk);
    while (sender_idles && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
    sb.take_byte(it);
  endtask

  task automatic send_datagram(input octet_q_t bytes);
    item_t it;
    foreach (bytes[i]) begin
      it.data_byte = bytes[i];
      it.end_of_datagram = (i == bytes.size() - 1);
      send_item(it);
    end
  endtask

  task automatic send_noise(input int len);
    octet_q_t bytes;
    repeat (len) bytes.push_back(8'($urandom_range(255)));
    send_datagram(bytes);
  endtask

  task automatic send_record(input logic [WORD_BITS-1:0] seq,
                             input logic [WORD_BITS-1:0] stat, input ft_set_t ft);
    logic [WORD_BITS-1:0] words [9];
    octet_q_t             bytes;
    words[SEQ_WORD] = seq;
    words[1] = $urandom;
    words[STATUS_WORD] = stat;
    for (int i = 0; i < FT_WORDS; i++) words[FT_FIRST + i] = ft[i];
    foreach (words[w])
      for (int b = 3; b >= 0; b--) bytes.push_back(words[w][8*b +: 8]);
    seq_sent = seq;
    send_datagram(bytes);
  endtask

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(24))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic ft_set_t rand_ft();
    ft_set_t ft;
    for (int i = 0; i < FT_WORDS; i++) ft[i] = rand_word();
    return ft;
  endfunction

  function automatic logic [WORD_BITS-1:0] next_seq();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return seq_sent + 1;
    if (pick < 75) return seq_sent + $urandom_range(2, 9);
    if (pick < 82) return seq_sent;
    if (pick < 90) return seq_sent - $urandom_range(1, 9);
    if (pick < 94) return seq_sent + 32'h8000_0000;
    if (pick < 97) return seq_sent + 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_datagram();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) send_record(next_seq(), rand_word(), rand_ft());
    else if (kind < 85) send_noise($urandom_range(1, 8));
    else if (kind < 93) send_noise($urandom_range(9, 40));
    else send_noise($urandom_range(37, 80));
  endtask

  // sender stops until every expected word is back, then lets the pipe settle
  task automatic await_all_samples();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_gains(input logic [WORD_BITS-1:0] fg, input logic [WORD_BITS-1:0] tg);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FORCE_GAIN;
    cfg_data <= fg;
    @(negedge clk);
    cfg_index <= CFG_TORQUE_GAIN;
    cfg_data <= tg;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_gains(fg, tg);
  endtask

  initial begin
    ft_set_t edge_ft;
    edge_ft = {32'h0001_0000, 32'h0000_0001, 32'h0000_0000,
               32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // size errors: single byte, one short, one over, long enough to saturate
    send_noise(1);
    send_noise(RECORD_BYTES - 1);
    send_noise(RECORD_BYTES + 1);
    send_noise(64);
    // sequence handling at reset gains, no idling on either side
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    send_record(32'h0000_0000, rand_word(), edge_ft);
    send_record(32'h0000_0001, 32'hFFFF_FFFF, edge_ft);
    send_record(32'h0000_0005, 32'h0000_0000, rand_ft());
    send_record(32'h0000_0002, rand_word(), rand_ft());
    send_record(32'h8000_0002, rand_word(), rand_ft());
    send_record(32'h0000_0001, rand_word(), edge_ft);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      await_all_samples();
      case (phase)
        0: write_gains(32'h0000_0000, 32'h0000_0000);
        1: write_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: write_gains(32'h0000_0001, 32'h8000_0000);
        default: write_gains($urandom, $urandom);
      endcase
      send_record(seq_sent + 32'd1, rand_word(), (phase == 3) ? rand_ft() : edge_ft);
    end

    // back-pressure: result side holds off while short datagrams keep coming
    await_all_samples();
    sender_idles = 1'b0;
    receiver_idles = 1'b1;
    stall_cycles = 300;
    repeat (16) send_noise(1);
    sender_idles = 1'b1;
    random_datagram();

    await_all_samples();
    repeat (12) @(posedge clk);
    if (sb.fails == 0)
      $display("sensor_record_sequence_checker_top_test: PASS");
    else
      $display("sensor_record_sequence_checker_top_test: FAIL");
    $finish;
  end

endmodule
